FILE: hw/rtl/unaligned_column_byte_write_top_macros.svh
// Assertion macros shared by the column byte write block.
`ifndef UNALIGNED_COLUMN_BYTE_WRITE_TOP_MACROS_SVH
`define UNALIGNED_COLUMN_BYTE_WRITE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// Clocked assertion that is switched off while reset is asserted.
`define UCBW_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("ucbw assertion failed");
// Clocked assertion that is also checked during reset.
`define UCBW_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("ucbw assertion failed");
`else
`define UCBW_ASSERT(lbl, clk, rstn, prop)
`define UCBW_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: hw/rtl/ucbw_pkg.sv
// Types, constants and helpers for the column byte write block.
`timescale 1ns / 1ps
package ucbw_pkg;

  // Display geometry.
  localparam int Pages   = 8;
  localparam int Columns = 128;
  localparam int Depth   = Pages * Columns;
  localparam int AddrW   = $clog2(Depth);

  // One input word.
  typedef struct packed {
    logic [5:0] pixel_row;
    logic [6:0] pixel_column;
    logic [7:0] pattern;
  } in_word_t;

  // One display write.
  typedef struct packed {
    logic [2:0] page;
    logic [6:0] column;
    logic [7:0] value;
    logic       last;
  } out_word_t;

  // Request to the frame memory: one write port and one read port.
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_UPPER = 4'b0100,
    ST_LOWER = 4'b1000
  } state_e;

  // Memory address of a page and column.
  function automatic logic [AddrW-1:0] byte_addr(logic [2:0] pg, logic [6:0] col);
    return AddrW'(32'(pg) * Columns + 32'(col));
  endfunction

  // Mask of the low off bits of a byte.
  function automatic logic [7:0] low_mask(logic [2:0] off);
    return 8'hFF >> (4'd8 - {1'b0, off});
  endfunction

endpackage

FILE: hw/rtl/ucbw_ram.sv
// Frame memory: one write port and one registered read port.
`timescale 1ns / 1ps
module ucbw_ram (
  input  logic              clk_i,
  input  ucbw_pkg::mem_req_t req_i,
  output logic [7:0]        rdata_o
);

  logic [7:0] mem [ucbw_pkg::Depth];
  logic [7:0] rdata_q;

  // Write and read; read data only changes when a read is issued.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/ucbw_ctrl.sv
// Sequencer: clearing pass, read-modify-write of one or two bytes, output register.
`timescale 1ns / 1ps
`include "unaligned_column_byte_write_top_macros.svh"
module ucbw_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ucbw_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ucbw_pkg::out_word_t out_word_o,
  output ucbw_pkg::mem_req_t  req_o,
  input  logic [7:0]          rdata_i
);

  ucbw_pkg::state_e            state_q, state_d;
  logic [ucbw_pkg::AddrW-1:0]  clear_q, clear_d;
  ucbw_pkg::in_word_t          item_q, item_d;
  logic [ucbw_pkg::AddrW-1:0]  addr_q, addr_d;
  logic                        out_valid_q, out_valid_d;
  ucbw_pkg::out_word_t         out_q, out_d;

  logic       out_free;
  logic       out_load;
  logic       in_ok;
  logic [2:0] pg;
  logic [2:0] off;
  logic [7:0] keep;
  logic [7:0] upper;
  logic [7:0] lower;
  logic       last_up;

  // Fields of the item being worked on and the merged bytes.
  assign pg      = item_q.pixel_row[5:3];
  assign off     = item_q.pixel_row[2:0];
  assign keep    = ucbw_pkg::low_mask(off);
  assign upper   = 8'(item_q.pattern << off) | (rdata_i & keep);
  assign lower   = 8'(item_q.pattern >> (4'd8 - {1'b0, off})) | (rdata_i & ~keep);
  assign last_up = (off == 3'd0) || ((32'(pg) + 1) >= ucbw_pkg::Pages);

  // Items outside the display are dropped without any write.
  assign in_ok = (32'(in_word_i.pixel_column) < ucbw_pkg::Columns) &&
                 (32'(in_word_i.pixel_row[5:3]) < ucbw_pkg::Pages);

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ucbw_pkg::ST_IDLE);

  // Next state, memory requests and output loading.
  always_comb begin
    state_d  = state_q;
    clear_d  = clear_q;
    item_d   = item_q;
    addr_d   = addr_q;
    out_d    = out_q;
    out_load = 1'b0;
    req_o    = '0;
    case (state_q)
      ucbw_pkg::ST_CLEAR: begin
        req_o.we    = 1'b1;
        req_o.waddr = clear_q;
        req_o.wdata = 8'h00;
        clear_d     = clear_q + ucbw_pkg::AddrW'(1);
        if (clear_q == ucbw_pkg::AddrW'(ucbw_pkg::Depth - 1)) begin
          state_d = ucbw_pkg::ST_IDLE;
        end
      end
      ucbw_pkg::ST_IDLE: begin
        if (in_valid_i && in_ok) begin
          item_d      = in_word_i;
          addr_d      = ucbw_pkg::byte_addr(in_word_i.pixel_row[5:3],
                                            in_word_i.pixel_column);
          req_o.re    = 1'b1;
          req_o.raddr = addr_d;
          state_d     = ucbw_pkg::ST_UPPER;
        end
      end
      ucbw_pkg::ST_UPPER: begin
        if (out_free) begin
          req_o.we     = 1'b1;
          req_o.waddr  = addr_q;
          req_o.wdata  = upper;
          out_load     = 1'b1;
          out_d.page   = pg;
          out_d.column = item_q.pixel_column;
          out_d.value  = upper;
          out_d.last   = last_up;
          if (last_up) begin
            state_d = ucbw_pkg::ST_IDLE;
          end else begin
            addr_d      = addr_q + ucbw_pkg::AddrW'(ucbw_pkg::Columns);
            req_o.re    = 1'b1;
            req_o.raddr = addr_d;
            state_d     = ucbw_pkg::ST_LOWER;
          end
        end
      end
      ucbw_pkg::ST_LOWER: begin
        if (out_free) begin
          req_o.we     = 1'b1;
          req_o.waddr  = addr_q;
          req_o.wdata  = lower;
          out_load     = 1'b1;
          out_d.page   = pg + 3'd1;
          out_d.column = item_q.pixel_column;
          out_d.value  = lower;
          out_d.last   = 1'b1;
          state_d      = ucbw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ucbw_pkg::ST_CLEAR;
        clear_d = '0;
      end
    endcase
    out_valid_d = out_load || (out_valid_q && out_stall_i);
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ucbw_pkg::ST_CLEAR;
      clear_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clear_q     <= clear_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    addr_q <= addr_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // No new word is taken while the memory is being cleared.
  `UCBW_ASSERT(a_clear_stalls, clk_i, rst_ni,
               (state_q == ucbw_pkg::ST_CLEAR) |-> in_stall_o)
  // A first write that is not the last one is always followed by the lower page.
  `UCBW_ASSERT(a_lower_follows, clk_i, rst_ni,
               (out_load && !out_d.last) |=> (state_q == ucbw_pkg::ST_LOWER))
  // A simultaneous read and write never touch the same byte.
  `UCBW_ASSERT(a_no_rw_clash, clk_i, rst_ni,
               (req_o.we && req_o.re) |-> (req_o.waddr != req_o.raddr))
  // The lower page is only reached straight from the upper page.
  `UCBW_ASSERT(a_lower_entry, clk_i, rst_ni,
               ((state_q == ucbw_pkg::ST_LOWER) && ($past(state_q) != ucbw_pkg::ST_LOWER))
               |-> ($past(state_q) == ucbw_pkg::ST_UPPER))

endmodule

FILE: hw/rtl/unaligned_column_byte_write_top.sv
// Top level of the unaligned column byte write block.
// Usage: the input channel (in_valid_i, in_stall_o, in_word_i) takes one word
// holding a pixel row, a display column and an 8-pixel vertical pattern. The
// output channel (out_valid_o, out_stall_i, out_word_o) gives one word per
// display byte written: page, column, new byte value and a last flag, which
// is set on the final write caused by an input word.
// After reset the frame memory is cleared one byte a cycle, all Pages *
// Columns bytes (1024 at the default geometry); the input stalls meanwhile.
// A word whose column or page lies outside the display is taken and dropped
// at once. An accepted word reads its upper byte through the registered read
// port; the merged byte is written back and sent out once the output register
// is free. An aligned row or a spill past the last page writes one byte per
// word; an unaligned row writes two, as the lower page needs a second read
// through the same read port. No new word is taken before the last write.
// When the receiver stalls, the output register holds its word and the
// sequencer waits before writing the next byte, so no write is lost.
`timescale 1ns / 1ps
module unaligned_column_byte_write_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ucbw_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ucbw_pkg::out_word_t out_word_o
);

  ucbw_pkg::mem_req_t req;
  logic [7:0]         rdata;

  // Sequencer and output register.
  ucbw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .req_o       (req),
    .rdata_i     (rdata)
  );

  // Frame memory.
  ucbw_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (req),
    .rdata_o (rdata)
  );

endmodule
